>>> hw/rtl/bfws_pkg.sv
// Package for the 5x5 box filter window sum block.
// Holds sizes, register indexes, the sequencer state type and the step and result words.
// Depends on nothing; the design files refer to it by scoped names, the testbench files import it.
package bfws_pkg;

	localparam int MAX_WIDTH  = 16;
	localparam int MAX_HEIGHT = 1024;
	localparam int WINDOW     = 5;
	localparam int HALF       = (WINDOW - 1) / 2;
	localparam int LINES      = WINDOW - 1;
	localparam int PIX_W      = 9;

	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int LANE_W     = $clog2(LINES);
	localparam int WID_W      = 5;
	localparam int HGT_W      = 11;
	localparam int ROW_W      = 11;
	localparam int CFG_W      = 11;
	localparam int LAG_W      = 6;
	localparam int SUM_W      = 14;
	localparam int ROWSUM_W   = PIX_W + $clog2(WINDOW);
	localparam int SUM_MAX    = WINDOW * WINDOW * ((1 << PIX_W) - 1);

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// Configuration register indexes and reset values
	localparam logic [0:0]       REG_WIDTH    = 1'b0;
	localparam logic [0:0]       REG_HEIGHT   = 1'b1;
	localparam logic [WID_W-1:0] WIDTH_RESET  = 5'd10;
	localparam logic [HGT_W-1:0] HEIGHT_RESET = 11'd8;

	typedef enum logic {
		ST_RUN,
		ST_FLUSH
	} state_t;

	typedef logic [PIX_W-1:0] pix_t;

	// One column of the line store: one pixel per ring lane
	typedef pix_t [LINES-1:0] line_word_t;

	// Window register, [row][column], column WINDOW-1 is the newest
	typedef pix_t [WINDOW-1:0][WINDOW-1:0] window_t;

	// One shift of the window, as issued by the sequencer
	typedef struct packed {
		logic              valid;
		logic              emit;
		logic [COL_W-1:0]  col;
		logic [LANE_W-1:0] lane;
		pix_t              pix;
		logic [WINDOW-1:0] row_mask;
		logic [WINDOW-1:0] col_mask;
		logic              frame_end;
		logic              run_last;
	} step_t;

	typedef struct packed {
		logic [SUM_W-1:0] window_sum;
		logic             frame_end;
		logic             run_last;
	} result_t;

endpackage

>>> hw/rtl/bfws_seq.sv
// Step sequencer of the box filter: input position, frame restart and end-of-frame flush.
// Issues one window shift per cycle with its padding masks and result flags, stalled by credit_ok and pixel_valid.
// Depends on bfws_pkg.
module bfws_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [bfws_pkg::WID_W-1:0]   eff_width,
	input  logic [bfws_pkg::HGT_W-1:0]   eff_height,
	input  logic                         credit_ok,
	input  logic                         pixel_valid,
	input  logic [bfws_pkg::PIX_W-1:0]   pixel,
	output logic                         pixel_ready,
	output bfws_pkg::step_t              step
);

	bfws_pkg::state_t                  state_q, state_d;
	logic [bfws_pkg::ROW_W-1:0]        row_q;
	logic [bfws_pkg::COL_W-1:0]        col_q;
	logic [bfws_pkg::LAG_W-1:0]        left_q;
	logic [bfws_pkg::LAG_W-1:0]        lag;

	logic                              take;
	logic                              fire;
	logic                              restart;
	logic                              last_px;
	logic                              flush_done;
	logic [bfws_pkg::ROW_W-1:0]        pos_row;
	logic [bfws_pkg::COL_W-1:0]        pos_col;
	logic [bfws_pkg::ROW_W-1:0]        nxt_row;
	logic [bfws_pkg::COL_W-1:0]        nxt_col;
	logic [bfws_pkg::WID_W:0]          csum;
	logic signed [bfws_pkg::ROW_W+1:0] row_s;
	logic signed [bfws_pkg::ROW_W+1:0] orow;
	logic [bfws_pkg::COL_W-1:0]        ocol;
	logic signed [bfws_pkg::ROW_W+1:0] y;
	logic signed [bfws_pkg::COL_W+1:0] x;
	logic [bfws_pkg::WINDOW-1:0]       row_mask;
	logic [bfws_pkg::WINDOW-1:0]       col_mask;

	// Handshake and issue
	always_comb begin
		pixel_ready = (state_q == bfws_pkg::ST_RUN) && credit_ok;
		take        = pixel_valid && pixel_ready;
		fire        = take || ((state_q == bfws_pkg::ST_FLUSH) && credit_ok);
		flush_done  = (left_q == bfws_pkg::LAG_W'(1));
	end

	// Restart the frame when the position lies outside the current size
	always_comb begin
		restart = ({1'b0, col_q} >= eff_width) || (row_q >= eff_height);
		if ((state_q == bfws_pkg::ST_RUN) && restart) begin
			pos_row = '0;
			pos_col = '0;
		end else begin
			pos_row = row_q;
			pos_col = col_q;
		end
		last_px = (pos_row == eff_height - 11'd1) && ({1'b0, pos_col} == eff_width - 5'd1);
		lag     = bfws_pkg::LAG_W'(bfws_pkg::HALF * eff_width + bfws_pkg::HALF);
	end

	// Advance in raster order
	always_comb begin
		if ({1'b0, pos_col} == eff_width - 5'd1) begin
			nxt_col = '0;
			nxt_row = pos_row + 11'd1;
		end else begin
			nxt_col = pos_col + 4'd1;
			nxt_row = pos_row;
		end
	end

	// Output position trails the step by two rows and two pixels
	always_comb begin
		row_s = $signed({2'b00, pos_row});
		csum  = {2'b00, pos_col} + {1'b0, eff_width};
		if (pos_col >= bfws_pkg::COL_W'(bfws_pkg::HALF)) begin
			ocol = pos_col - bfws_pkg::COL_W'(bfws_pkg::HALF);
			orow = row_s - $signed((bfws_pkg::ROW_W+2)'(bfws_pkg::HALF));
		end else if (csum >= (bfws_pkg::WID_W+1)'(bfws_pkg::HALF)) begin
			ocol = bfws_pkg::COL_W'(csum - (bfws_pkg::WID_W+1)'(bfws_pkg::HALF));
			orow = row_s - $signed((bfws_pkg::ROW_W+2)'(bfws_pkg::HALF + 1));
		end else begin
			// single-pixel rows: both pixels of lag borrow a whole row
			ocol = '0;
			orow = row_s - $signed((bfws_pkg::ROW_W+2)'(2 * bfws_pkg::HALF));
		end
	end

	// Zero padding masks of the window around the output position
	always_comb begin
		y = '0;
		x = '0;
		for (int r = 0; r < bfws_pkg::WINDOW; r++) begin
			y = orow + $signed((bfws_pkg::ROW_W+2)'(r))
				- $signed((bfws_pkg::ROW_W+2)'(bfws_pkg::HALF));
			row_mask[r] = !y[bfws_pkg::ROW_W+1] && (y < $signed({2'b00, eff_height}));
		end
		for (int k = 0; k < bfws_pkg::WINDOW; k++) begin
			x = $signed({2'b00, ocol}) + $signed((bfws_pkg::COL_W+2)'(k))
				- $signed((bfws_pkg::COL_W+2)'(bfws_pkg::HALF));
			col_mask[k] = !x[bfws_pkg::COL_W+1] && (x < $signed({1'b0, eff_width}));
		end
	end

	// Step word
	always_comb begin
		step.valid     = fire;
		step.emit      = !orow[bfws_pkg::ROW_W+1];
		step.col       = pos_col;
		step.lane      = pos_row[bfws_pkg::LANE_W-1:0];
		step.pix       = (state_q == bfws_pkg::ST_FLUSH) ? '0 : pixel;
		step.row_mask  = row_mask;
		step.col_mask  = col_mask;
		step.frame_end = (orow == $signed({2'b00, eff_height}) - 13'sd1)
			&& ({1'b0, ocol} == eff_width - 5'd1);
		if (state_q == bfws_pkg::ST_FLUSH) begin
			step.run_last = flush_done;
		end else begin
			step.run_last = !orow[bfws_pkg::ROW_W+1] && !last_px;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bfws_pkg::ST_RUN: begin
				if (take && last_px) begin
					state_d = bfws_pkg::ST_FLUSH;
				end
			end
			bfws_pkg::ST_FLUSH: begin
				if (fire && flush_done) begin
					state_d = bfws_pkg::ST_RUN;
				end
			end
			default: state_d = bfws_pkg::ST_RUN;
		endcase
	end

	// Position and flush count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfws_pkg::ST_RUN;
			row_q   <= '0;
			col_q   <= '0;
			left_q  <= '0;
		end else begin
			state_q <= state_d;
			if (fire) begin
				if ((state_q == bfws_pkg::ST_FLUSH) && flush_done) begin
					row_q <= '0;
					col_q <= '0;
				end else begin
					row_q <= nxt_row;
					col_q <= nxt_col;
				end
				if (state_q == bfws_pkg::ST_RUN) begin
					left_q <= lag;
				end else begin
					left_q <= left_q - bfws_pkg::LAG_W'(1);
				end
			end
		end
	end

endmodule

>>> hw/rtl/bfws_linebuf.sv
// Line store and window register of the box filter.
// One memory word per column holds the four stored rows; read, patch one lane, write back.
// Depends on bfws_pkg.
module bfws_linebuf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bfws_pkg::step_t      step,
	output bfws_pkg::window_t    window,
	output bfws_pkg::step_t      step_s2,
	output logic                 pend_s1
);

	bfws_pkg::line_word_t        line_mem_q [bfws_pkg::MAX_WIDTH];
	bfws_pkg::line_word_t        rd_data_q;
	bfws_pkg::line_word_t        wr_word_q;
	logic [bfws_pkg::COL_W-1:0]  wr_col_q;
	logic                        wr_vld_q;
	bfws_pkg::step_t             step_s1;
	bfws_pkg::step_t             ctrl_s2;
	bfws_pkg::window_t           window_q;

	bfws_pkg::line_word_t        word;
	bfws_pkg::line_word_t        new_word;
	bfws_pkg::pix_t [bfws_pkg::WINDOW-1:0] column;
	logic [bfws_pkg::LANE_W-1:0] lane_idx;

	// Read the column word, write back the patched word of the step ahead
	always_ff @(posedge clk) begin
		rd_data_q <= line_mem_q[step.col];
		if (step_s1.valid) begin
			line_mem_q[step_s1.col] <= new_word;
		end
	end

	// Hold the last write for forwarding to a read issued at the same edge
	always_ff @(posedge clk) begin
		wr_word_q <= new_word;
		wr_col_q  <= step_s1.col;
	end

	// Advance the step into the read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_q <= 1'b0;
			step_s1  <= '0;
		end else begin
			wr_vld_q <= step_s1.valid;
			step_s1  <= step;
		end
	end

	// Pick the column, oldest row first, and patch the current row's lane
	always_comb begin
		lane_idx = '0;
		if (wr_vld_q && (wr_col_q == step_s1.col)) begin
			word = wr_word_q;
		end else begin
			word = rd_data_q;
		end
		for (int r = 0; r < bfws_pkg::LINES; r++) begin
			lane_idx  = step_s1.lane + bfws_pkg::LANE_W'(r);
			column[r] = word[lane_idx];
		end
		column[bfws_pkg::LINES] = step_s1.pix;
		new_word = word;
		new_word[step_s1.lane] = step_s1.pix;
	end

	// Shift the new column into the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (step_s1.valid) begin
			for (int r = 0; r < bfws_pkg::WINDOW; r++) begin
				for (int k = 0; k < bfws_pkg::WINDOW - 1; k++) begin
					window_q[r][k] <= window_q[r][k+1];
				end
				window_q[r][bfws_pkg::WINDOW-1] <= column[r];
			end
		end
	end

	// Pass only result-bearing steps on to the adders
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else begin
			ctrl_s2.valid     <= step_s1.valid && step_s1.emit;
			ctrl_s2.emit      <= step_s1.emit;
			ctrl_s2.col       <= step_s1.col;
			ctrl_s2.lane      <= step_s1.lane;
			ctrl_s2.pix       <= step_s1.pix;
			ctrl_s2.row_mask  <= step_s1.row_mask;
			ctrl_s2.col_mask  <= step_s1.col_mask;
			ctrl_s2.frame_end <= step_s1.frame_end;
			ctrl_s2.run_last  <= step_s1.run_last;
		end
	end

	assign window  = window_q;
	assign step_s2 = ctrl_s2;
	assign pend_s1 = step_s1.valid && step_s1.emit;

endmodule

>>> hw/rtl/bfws_sum.sv
// Masked adder pipeline of the box filter.
// Row sums over the masked window columns, then the sum over the masked rows.
// Depends on bfws_pkg.
module bfws_sum (
	input  logic                clk,
	input  logic                arst_n,
	input  bfws_pkg::window_t   window,
	input  bfws_pkg::step_t     step_s2,
	output logic                push,
	output bfws_pkg::result_t   push_data
);

	logic [bfws_pkg::ROWSUM_W-1:0] rowsum [bfws_pkg::WINDOW];
	logic [bfws_pkg::ROWSUM_W-1:0] rowsum_s3 [bfws_pkg::WINDOW];
	logic [bfws_pkg::ROWSUM_W-1:0] acc;
	logic [bfws_pkg::SUM_W-1:0]    total;
	logic                          valid_s3;
	logic                          frame_end_s3;
	logic                          run_last_s3;

	// Add each window row over the columns inside the image
	always_comb begin
		acc = '0;
		for (int r = 0; r < bfws_pkg::WINDOW; r++) begin
			acc = '0;
			for (int k = 0; k < bfws_pkg::WINDOW; k++) begin
				if (step_s2.col_mask[k]) begin
					acc = acc + bfws_pkg::ROWSUM_W'(window[r][k]);
				end
			end
			rowsum[r] = acc;
		end
	end

	// Drop rows outside the image
	always_ff @(posedge clk) begin
		for (int r = 0; r < bfws_pkg::WINDOW; r++) begin
			rowsum_s3[r] <= step_s2.row_mask[r] ? rowsum[r] : '0;
		end
		frame_end_s3 <= step_s2.frame_end;
		run_last_s3  <= step_s2.run_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= step_s2.valid;
		end
	end

	// Add the row sums
	always_comb begin
		total = '0;
		for (int r = 0; r < bfws_pkg::WINDOW; r++) begin
			total = total + bfws_pkg::SUM_W'(rowsum_s3[r]);
		end
	end

	assign push                 = valid_s3;
	assign push_data.window_sum = total;
	assign push_data.frame_end  = frame_end_s3;
	assign push_data.run_last   = run_last_s3;

endmodule

>>> hw/rtl/bfws_fifo.sv
// Result queue of the box filter: parts the adder pipeline from the output handshake.
// Register-based, one write and one read pointer.
// Depends on bfws_pkg.
module bfws_fifo (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  bfws_pkg::result_t           push_data,
	input  logic                        pop_ready,
	output logic                        pop_valid,
	output bfws_pkg::result_t           pop_data,
	output logic [bfws_pkg::CNT_W-1:0]  count
);

	bfws_pkg::result_t            entry_q [bfws_pkg::FIFO_DEPTH];
	logic [bfws_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [bfws_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [bfws_pkg::CNT_W-1:0]   count_q;
	logic                         pop;

	assign pop_valid = (count_q != '0);
	assign pop       = pop_valid && pop_ready;
	assign pop_data  = entry_q[rd_ptr_q];
	assign count     = count_q;

	// Store the incoming word
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and track fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + bfws_pkg::FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + bfws_pkg::FIFO_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + bfws_pkg::CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - bfws_pkg::CNT_W'(1);
			end
		end
	end

endmodule

>>> hw/rtl/box_filter_window_sum.sv
// Top level of the 5x5 box filter window sum block.
// Holds the configuration registers and joins sequencer, line store, adders and result queue.
// Depends on bfws_pkg, bfws_seq, bfws_linebuf, bfws_sum and bfws_fifo.
//
//   channel   direction  handshake                  word
//   pixel     in         pixel_valid/pixel_ready    pixel
//   result    out        result_valid/result_ready  window_sum, frame_end, run_last
//   cfg       in         cfg_wen                    cfg_index, cfg_data
//
// One pixel per cycle while pixel_ready is high. A frame's last pixel starts 2*width+2 flush
// steps, up to one result each, with pixel_ready low. A result passes the line store read,
// window shift, row sums and final add into the result queue before it is offered.
// Reset does not clear the line store; entries from before the frame fall outside the
// image and are masked. An 8-entry result queue absorbs output stalls; pixel_ready drops
// when queued plus in-flight results would fill it.
module box_filter_window_sum (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [0:0]                  cfg_index,
	input  logic [bfws_pkg::CFG_W-1:0]  cfg_data,
	input  logic                        pixel_valid,
	output logic                        pixel_ready,
	input  logic [bfws_pkg::PIX_W-1:0]  pixel,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic [bfws_pkg::SUM_W-1:0]  window_sum,
	output logic                        frame_end,
	output logic                        run_last
);

	logic [bfws_pkg::WID_W-1:0] width_q;
	logic [bfws_pkg::HGT_W-1:0] height_q;
	logic [bfws_pkg::WID_W-1:0] eff_width;
	logic [bfws_pkg::HGT_W-1:0] eff_height;
	logic [bfws_pkg::CNT_W-1:0] fifo_count;
	logic [bfws_pkg::CNT_W:0]   load;
	logic                       credit_ok;
	logic                       pend_s1;
	logic                       push;
	bfws_pkg::step_t            step;
	bfws_pkg::step_t            step_s2;
	bfws_pkg::window_t          window;
	bfws_pkg::result_t          push_data;
	bfws_pkg::result_t          pop_data;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bfws_pkg::WIDTH_RESET;
			height_q <= bfws_pkg::HEIGHT_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				bfws_pkg::REG_WIDTH:  width_q  <= cfg_data[bfws_pkg::WID_W-1:0];
				bfws_pkg::REG_HEIGHT: height_q <= cfg_data[bfws_pkg::HGT_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the frame size to the supported range
	always_comb begin
		if (width_q == '0) begin
			eff_width = bfws_pkg::WID_W'(1);
		end else if (width_q > bfws_pkg::WID_W'(bfws_pkg::MAX_WIDTH)) begin
			eff_width = bfws_pkg::WID_W'(bfws_pkg::MAX_WIDTH);
		end else begin
			eff_width = width_q;
		end
		if (height_q == '0) begin
			eff_height = bfws_pkg::HGT_W'(1);
		end else if (height_q > bfws_pkg::HGT_W'(bfws_pkg::MAX_HEIGHT)) begin
			eff_height = bfws_pkg::HGT_W'(bfws_pkg::MAX_HEIGHT);
		end else begin
			eff_height = height_q;
		end
	end

	// Issue only while the queue has room for every result in flight
	always_comb begin
		load = (bfws_pkg::CNT_W+1)'(fifo_count) + (bfws_pkg::CNT_W+1)'(pend_s1)
			+ (bfws_pkg::CNT_W+1)'(step_s2.valid) + (bfws_pkg::CNT_W+1)'(push);
		credit_ok = (load < (bfws_pkg::CNT_W+1)'(bfws_pkg::FIFO_DEPTH));
	end

	bfws_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.eff_width   (eff_width),
		.eff_height  (eff_height),
		.credit_ok   (credit_ok),
		.pixel_valid (pixel_valid),
		.pixel       (pixel),
		.pixel_ready (pixel_ready),
		.step        (step)
	);

	bfws_linebuf u_linebuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.window  (window),
		.step_s2 (step_s2),
		.pend_s1 (pend_s1)
	);

	bfws_sum u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.window    (window),
		.step_s2   (step_s2),
		.push      (push),
		.push_data (push_data)
	);

	bfws_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop_ready (result_ready),
		.pop_valid (result_valid),
		.pop_data  (pop_data),
		.count     (fifo_count)
	);

	assign window_sum = pop_data.window_sum;
	assign frame_end  = pop_data.frame_end;
	assign run_last   = pop_data.run_last;

endmodule

>>> hw/rtl/bfws_checker.sv
// Port checker of the box filter window sum block, bound to the top level.
// Watches the result channel only.
// Depends on bfws_pkg.
module bfws_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        result_valid,
	input  logic                        result_ready,
	input  logic [bfws_pkg::SUM_W-1:0]  window_sum,
	input  logic                        frame_end,
	input  logic                        run_last
);

	// Hold a stalled result word
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(window_sum)
			&& $stable(frame_end) && $stable(run_last))
		else $error("result word changed while stalled");

	// The frame's last result closes the flush run
	a_frame_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_end |-> run_last)
		else $error("frame end without run end");

	// A window of 25 pixels cannot exceed its full-scale sum
	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> window_sum <= bfws_pkg::SUM_W'(bfws_pkg::SUM_MAX))
		else $error("window sum above full scale");

endmodule

bind box_filter_window_sum bfws_checker u_bfws_checker (.*);

>>> sim/bfws_window_check.sv
// Checker for the box filter window sum block: mirrors register writes, predicts each
// window sum from the accepted pixel words and compares it with every result word.
// Depends on bfws_pkg; instantiated beside the block by tb.
module bfws_window_check (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [0:0]                  cfg_index,
	input  logic [bfws_pkg::CFG_W-1:0]  cfg_data,
	input  logic                        pixel_valid,
	input  logic                        pixel_ready,
	input  logic [bfws_pkg::PIX_W-1:0]  pixel,
	input  logic                        result_valid,
	input  logic                        result_ready,
	input  logic [bfws_pkg::SUM_W-1:0]  window_sum,
	input  logic                        frame_end,
	input  logic                        run_last,
	output int unsigned                 errors = 0,
	output int unsigned                 pending = 0
);
	import bfws_pkg::*;

	pix_t             line_mem [LINES][MAX_WIDTH];
	pix_t             win [WINDOW][WINDOW];
	logic [WID_W-1:0] width_reg;
	logic [HGT_W-1:0] height_reg;
	int               next_col;
	int               next_row;
	result_t          sums_due [$];
	result_t          want;

	// Clamp the width register to the line store
	function automatic int cols_used();
		int w;
		w = width_reg;
		if (w == 0) w = 1;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		return w;
	endfunction

	function automatic int rows_used();
		int h;
		h = height_reg;
		if (h == 0) h = 1;
		if (h > MAX_HEIGHT) h = MAX_HEIGHT;
		return h;
	endfunction

	// Read the column above (oldest row first), store the new pixel, shift the window left
	task automatic shift_in(input int row, input int col, input pix_t pix);
		pix_t column [WINDOW];
		for (int r = 0; r < LINES; r++)
			column[r] = line_mem[(row + r) % LINES][col];
		column[LINES] = pix;
		line_mem[row % LINES][col] = pix;
		for (int r = 0; r < WINDOW; r++) begin
			for (int k = 0; k < WINDOW - 1; k++)
				win[r][k] = win[r][k + 1];
			win[r][WINDOW - 1] = column[r];
		end
	endtask

	// Sum the window for output position o, padding outside the image with zero
	function automatic result_t window_at(input int o, input int w, input int h);
		int      orow;
		int      ocol;
		int      y;
		int      x;
		int      total;
		result_t res;
		orow  = o / w;
		ocol  = o % w;
		total = 0;
		for (int r = 0; r < WINDOW; r++) begin
			for (int k = 0; k < WINDOW; k++) begin
				y = orow - HALF + r;
				x = ocol - HALF + k;
				if (y >= 0 && y < h && x >= 0 && x < w)
					total += win[r][k];
			end
		end
		res.window_sum = total[SUM_W-1:0];
		res.frame_end  = (o == w * h - 1);
		res.run_last   = 1'b0;
		return res;
	endfunction

	// Advance the window by one pixel word; the last pixel of a frame flushes the lag
	task automatic predict_window_sums(input pix_t pix);
		int      w;
		int      h;
		int      lag;
		int      i;
		int      j;
		int      n_out;
		result_t run [$];
		w   = cols_used();
		h   = rows_used();
		lag = HALF * w + HALF;
		if (next_col >= w || next_row >= h) begin
			next_col = 0;
			next_row = 0;
		end
		i = next_row * w + next_col;
		shift_in(next_row, next_col, pix);
		if (i >= lag) run.push_back(window_at(i - lag, w, h));
		if (i == w * h - 1) begin
			for (int v = 1; v <= lag; v++) begin
				j = i + v;
				shift_in(j / w, j % w, '0);
				if (j >= lag) run.push_back(window_at(j - lag, w, h));
			end
			next_col = 0;
			next_row = 0;
		end else begin
			next_col++;
			if (next_col >= w) begin
				next_col = 0;
				next_row++;
			end
		end
		n_out = run.size();
		for (int k = 0; k < n_out; k++) begin
			want = run[k];
			want.run_last = (k == n_out - 1);
			sums_due.push_back(want);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg  = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			next_col   = 0;
			next_row   = 0;
			for (int r = 0; r < WINDOW; r++)
				for (int k = 0; k < WINDOW; k++)
					win[r][k] = '0;
			for (int r = 0; r < LINES; r++)
				for (int k = 0; k < MAX_WIDTH; k++)
					line_mem[r][k] = '0;
			sums_due.delete();
			pending = 0;
		end else begin
			// Track register writes
			if (cfg_wen) begin
				case (cfg_index)
					REG_WIDTH:  width_reg  = cfg_data[WID_W-1:0];
					REG_HEIGHT: height_reg = cfg_data[HGT_W-1:0];
					default: ;
				endcase
			end
			// Predict from each accepted pixel word
			if (pixel_valid && pixel_ready)
				predict_window_sums(pixel);
			// Compare each accepted result word with the oldest prediction
			if (result_valid && result_ready) begin
				if (sums_due.size() == 0) begin
					errors++;
					$error("result word with none expected: window_sum %0d frame_end %0d run_last %0d",
						window_sum, frame_end, run_last);
				end else begin
					want = sums_due.pop_front();
					if (window_sum !== want.window_sum) begin
						errors++;
						$error("window_sum: expected %0d, got %0d", want.window_sum, window_sum);
					end
					if (frame_end !== want.frame_end) begin
						errors++;
						$error("frame_end: expected %0d, got %0d", want.frame_end, frame_end);
					end
					if (run_last !== want.run_last) begin
						errors++;
						$error("run_last: expected %0d, got %0d", want.run_last, run_last);
					end
				end
			end
			pending = sums_due.size();
		end
	end

endmodule

>>> sim/tb.sv
// Top of the box filter window sum testbench: clock, reset, register writes, pixel and
// result pacing, and the verdict. Depends on bfws_pkg, box_filter_window_sum and
// bfws_window_check, which does all prediction and comparison.
module tb;
	import bfws_pkg::*;

	typedef enum int {
		PACE_FULL,
		PACE_SEND_GAPS,
		PACE_RECV_STALLS,
		PACE_BOTH
	} pace_t;

	localparam int HOLD_CYCLES   = 200;
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_PIXELS = 110;
	localparam int PIX_MAX       = (1 << PIX_W) - 1;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             cfg_wen      = 1'b0;
	logic [0:0]       cfg_index    = REG_WIDTH;
	logic [CFG_W-1:0] cfg_data     = '0;
	logic             pixel_valid  = 1'b0;
	logic             pixel_ready;
	pix_t             pixel        = '0;
	logic             result_valid;
	logic             result_ready = 1'b0;
	logic [SUM_W-1:0] window_sum;
	logic             frame_end;
	logic             run_last;
	int unsigned      errors;
	int unsigned      pending;

	int send_gap_pct   = 0;
	int recv_stall_pct = 0;
	int hold_reqs      = 0;
	int hold_seen      = 0;
	int hold_left      = 0;
	int width_raw      = WIDTH_RESET;
	int height_raw     = HEIGHT_RESET;
	int pixels_sent    = 0;

	always #2 clk = ~clk;

	box_filter_window_sum i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.window_sum   (window_sum),
		.frame_end    (frame_end),
		.run_last     (run_last)
	);

	bfws_window_check i_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.window_sum   (window_sum),
		.frame_end    (frame_end),
		.run_last     (run_last),
		.errors       (errors),
		.pending      (pending)
	);

	// Pace the result side; a hold-off request blocks it for a long stretch
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Give up after a generous fixed time
	initial begin
		#1_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic set_pace(input pace_t pace);
		case (pace)
			PACE_FULL:        begin send_gap_pct = 0;  recv_stall_pct = 0;  end
			PACE_SEND_GAPS:   begin send_gap_pct = 80; recv_stall_pct = 0;  end
			PACE_RECV_STALLS: begin send_gap_pct = 0;  recv_stall_pct = 80; end
			PACE_BOTH:        begin send_gap_pct = 17; recv_stall_pct = 17; end
			default: ;
		endcase
	endtask

	task automatic write_reg(input logic [0:0] idx, input int data);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data[CFG_W-1:0];
		@(negedge clk);
		cfg_wen   <= 1'b0;
		if (idx == REG_WIDTH) width_raw = data & ((1 << WID_W) - 1);
		else height_raw = data & ((1 << HGT_W) - 1);
	endtask

	task automatic configure(input int w_data, input int h_data);
		write_reg(REG_WIDTH, w_data);
		write_reg(REG_HEIGHT, h_data);
	endtask

	function automatic int frame_cols();
		return (width_raw == 0) ? 1 : (width_raw > MAX_WIDTH) ? MAX_WIDTH : width_raw;
	endfunction

	function automatic int frame_rows();
		return (height_raw == 0) ? 1 : (height_raw > MAX_HEIGHT) ? MAX_HEIGHT : height_raw;
	endfunction

	function automatic pix_t random_pixel();
		case ($urandom_range(0, 7))
			0:       return pix_t'(PIX_MAX);
			1:       return '0;
			default: return pix_t'($urandom_range(0, PIX_MAX));
		endcase
	endfunction

	// Offer one pixel word, with random gaps before it, and hold it until taken
	task automatic push_pixel(input pix_t v);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			pixel_valid <= 1'b0;
			@(negedge clk);
		end
		pixel_valid <= 1'b1;
		pixel       <= v;
		@(posedge clk);
		while (!pixel_ready) @(posedge clk);
		pixels_sent++;
	endtask

	// Stop sending and wait until every expected result word has come out
	task automatic drain();
		@(negedge clk);
		pixel_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic push_frame(input bit bright);
		int n;
		n = frame_cols() * frame_rows();
		for (int k = 0; k < n; k++)
			push_pixel(bright && $urandom_range(0, 9) != 0 ? pix_t'(PIX_MAX) : random_pixel());
	endtask

	// Send part of a frame, then shrink the size below the current position so the
	// next pixel starts a new frame and the pending tail is dropped
	task automatic break_frame(input int count);
		int row;
		int col;
		for (int k = 0; k < count; k++) push_pixel(random_pixel());
		drain();
		row = count / frame_cols();
		col = count % frame_cols();
		if (row > 0) write_reg(REG_HEIGHT, row);
		else write_reg(REG_WIDTH, col);
		push_frame(1'b0);
	endtask

	initial begin
		int phase;
		int w_pick;
		int h_pick;
		int n;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		set_pace(PACE_FULL);

		// Frame at the reset size
		push_frame(1'b0);
		drain();

		// Single pixel frame, then zero sizes read as one
		configure(1, 1);
		push_pixel(pix_t'(PIX_MAX));
		drain();
		configure(0, 0);
		push_pixel(9'h155);
		drain();

		// Frame smaller than the lag: all results come in the flush
		configure(2, 2);
		push_pixel(pix_t'(PIX_MAX));
		push_pixel('0);
		push_pixel(9'h0AA);
		push_pixel(pix_t'(PIX_MAX));
		drain();

		// Width above the line store saturates; upper data bits are dropped
		configure(11'h7FF, 1);
		for (int k = 0; k < MAX_WIDTH; k++)
			push_pixel((k % 2) ? pix_t'(PIX_MAX) : pix_t'(0));
		drain();

		// Size shrunk mid-frame restarts the frame
		configure(5, 3);
		break_frame(3);
		drain();

		// Full width with mostly full-scale pixels pushes the sums towards the largest sum
		set_pace(PACE_BOTH);
		configure(MAX_WIDTH, 5);
		push_frame(1'b1);
		drain();

		// Height above the row limit, cut short by shrinking it below the position
		configure(1, 11'h7FF);
		break_frame(6);
		drain();

		// Random sizes, pacing and content; every pacing phase runs at least once
		pixels_sent = 0;
		phase = 0;
		while (pixels_sent < RANDOM_PIXELS || phase < 4) begin
			set_pace(pace_t'(phase % 4));
			if (phase == 3) begin
				// Stall the result side for long while pixels keep coming
				configure(MAX_WIDTH, 4);
				send_gap_pct = 0;
				hold_reqs++;
				push_frame(1'b0);
			end else begin
				case ($urandom_range(0, 9))
					0:       w_pick = 0;
					1:       w_pick = $urandom_range(MAX_WIDTH + 1, (1 << WID_W) - 1);
					2:       w_pick = MAX_WIDTH;
					default: w_pick = $urandom_range(1, 8);
				endcase
				if ($urandom_range(0, 3) == 0)
					w_pick |= $urandom_range(1, (1 << (CFG_W - WID_W)) - 1) << WID_W;
				case ($urandom_range(0, 9))
					0:       h_pick = 0;
					1:       h_pick = $urandom_range(7, 10);
					default: h_pick = $urandom_range(1, 5);
				endcase
				configure(w_pick, h_pick);
				n = frame_cols() * frame_rows();
				if (n > 1 && $urandom_range(0, 5) == 0)
					break_frame($urandom_range(1, n - 1));
				repeat ($urandom_range(1, 2)) push_frame(1'b0);
			end
			drain();
			phase++;
		end

		repeat (40) @(negedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/bfws_pkg.sv
hw/rtl/bfws_seq.sv
hw/rtl/bfws_linebuf.sv
hw/rtl/bfws_sum.sv
hw/rtl/bfws_fifo.sv
hw/rtl/box_filter_window_sum.sv
hw/rtl/bfws_checker.sv
sim/bfws_window_check.sv
sim/tb.sv
